>>> design/fcp_pkg.sv
// Package for the fan curve PWM ramp controller.
// Field widths, register indexes, and the command and status types shared by
// the controller, the datapath and the top level. No dependencies.
package fcp_pkg;

   localparam int TEMP_W = 19;
   localparam int TADJ_W = 21;
   localparam int DUTY_W = 8;
   localparam int TACH_W = 16;
   localparam int HYST_W = 16;
   localparam int GAIN_W = 32;
   localparam int STEP_W = 9;
   localparam int DIFF_W = 19;
   localparam int X_W = 2 * DIFF_W;
   localparam int X_HI_W = X_W - GAIN_W;
   localparam int MUL_W = 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int HI_W = GAIN_W + X_HI_W;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0] STEP_MAX = '1;
   localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURVE_MODE = 4'd0,
      CSR_LOW_TEMP = 4'd1,
      CSR_HIGH_TEMP = 4'd2,
      CSR_STOP_HYST = 4'd3,
      CSR_FLOOR_DUTY = 4'd4,
      CSR_KEEP_DUTY = 4'd5,
      CSR_CEIL_DUTY = 4'd6,
      CSR_CURVE_GAIN = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic load_item;
      logic setup;
      logic square;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic window_out;
      logic quadratic;
      logic out_free;
   } status_type;

endpackage

>>> design/fcp_if.sv
// Channel interfaces of the fan curve PWM ramp controller.
// Depends on fcp_pkg for the field widths.
interface fcp_req_if;
   import fcp_pkg::*;
   logic valid;
   logic ready;
   logic signed [TEMP_W-1:0] temperature;
   logic [DUTY_W-1:0] present_duty;
   logic [TACH_W-1:0] tach_speed;
   modport source (output valid, temperature, present_duty, tach_speed, input ready);
   modport sink (input valid, temperature, present_duty, tach_speed, output ready);
endinterface

interface fcp_rsp_if;
   import fcp_pkg::*;
   logic valid;
   logic ready;
   logic [DUTY_W-1:0] new_duty;
   logic start_pulse;
   modport source (output valid, new_duty, start_pulse, input ready);
   modport sink (input valid, new_duty, start_pulse, output ready);
endinterface

interface fcp_csr_if;
   import fcp_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

>>> design/fan_curve_pwm_ramp_control.sv
// Top level of the fan curve PWM ramp controller.
// Depends on fcp_pkg, fcp_if, fcp_ctrl and fcp_datapath.
//
// Channel  Direction  Carries
// req_ch   in         temperature, present_duty, tach_speed
// rsp_ch   out        new_duty, start_pulse
// csr_ch   in         index, wdata (register write, always ready)
//
// Outside the curve window an item passes through setup and finish; on the
// linear curve it also takes the low and high partial gain products on the shared
// 32x32 multiplier and a sum, and on the quadratic curve a square before them.
// The result register loads on the same edge on which req_ready returns.
// Reset loads the register defaults and clears the ramp step.
// A result waiting in the output register stalls the next item only at its
// final step; req_ready is high whenever no item is in work.
module fan_curve_pwm_ramp_control (
   input  logic      clock,
   input  logic      reset,
   fcp_req_if.sink   req_ch,
   fcp_rsp_if.source rsp_ch,
   fcp_csr_if.sink   csr_ch
);
   import fcp_pkg::*;

   cmd_type cmd;
   status_type status;

   fcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_temperature  (req_ch.temperature),
      .req_present_duty (req_ch.present_duty),
      .req_tach_speed   (req_ch.tach_speed),
      .rsp_ch           (rsp_ch),
      .csr_ch           (csr_ch),
      .cmd              (cmd),
      .status           (status)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) cmd.load_item |=> cmd.setup)
      else $error("accepted transaction did not enter setup");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.setup, cmd.square, cmd.mul_lo, cmd.mul_hi,
                cmd.sum, cmd.finish}))
      else $error("more than one datapath command at once");
   assert property (@(posedge clock) disable iff (reset) cmd.finish |-> status.out_free)
      else $error("result register overwritten");
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.start_pulse |-> rsp_ch.new_duty != '0)
      else $error("start pulse with zero duty");
`endif

endmodule

>>> design/fcp_ctrl.sv
// Sequencing state machine of the fan curve PWM ramp controller.
// Depends on fcp_pkg; drives the datapath commands from its status.
module fcp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fcp_pkg::status_type status,
   output fcp_pkg::cmd_type    cmd
);
   import fcp_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SETUP  = 7'b0000010,
      ST_SQUARE = 7'b0000100,
      ST_MUL_LO = 7'b0001000,
      ST_MUL_HI = 7'b0010000,
      ST_SUM    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (status.window_out) begin
               state_in = ST_FINISH;
            end else if (status.quadratic) begin
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/fcp_datapath.sv
// Datapath of the fan curve PWM ramp controller: registers, curve math on a
// shared 32x32 multiplier, ramp state and the result register.
// Depends on fcp_pkg and fcp_if; steered by fcp_ctrl commands.
module fcp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [fcp_pkg::TEMP_W-1:0]  req_temperature,
   input  logic [fcp_pkg::DUTY_W-1:0]         req_present_duty,
   input  logic [fcp_pkg::TACH_W-1:0]         req_tach_speed,
   fcp_rsp_if.source                          rsp_ch,
   fcp_csr_if.sink                            csr_ch,
   input  fcp_pkg::cmd_type                   cmd,
   output fcp_pkg::status_type                status
);
   import fcp_pkg::*;

   logic curve_mode_ff;
   logic signed [TEMP_W-1:0] low_temp_ff;
   logic signed [TEMP_W-1:0] high_temp_ff;
   logic [HYST_W-1:0] stop_hyst_ff;
   logic [DUTY_W-1:0] floor_duty_ff;
   logic [DUTY_W-1:0] keep_duty_ff;
   logic [DUTY_W-1:0] ceil_duty_ff;
   logic [GAIN_W-1:0] curve_gain_ff;

   logic signed [TADJ_W-1:0] temp_ext, hyst_ext, t_in, t_ff;
   logic signed [TADJ_W-1:0] low_ext, high_ext, diff;
   logic below, above;
   logic [DUTY_W-1:0] present_ff;
   logic stopped_ff;
   logic [DIFF_W-1:0] d_ff;
   logic [X_W-1:0] x_ff;
   logic [MUL_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [GAIN_W-1:0] acc_ff;
   logic [HI_W-1:0] hi_ff;
   logic [HI_W:0] term;
   logic [DUTY_W-1:0] term_sat;
   logic [DUTY_W:0] curve_sum;
   logic [DUTY_W-1:0] target_ff;

   logic [STEP_W-1:0] step_ff, step_in, step_inc;
   logic [STEP_W:0] step_dbl;
   logic [DUTY_W+1:0] ramp_sum;
   logic [DUTY_W-1:0] nd;

   logic rsp_valid_ff;
   logic [DUTY_W-1:0] rsp_duty_ff;
   logic rsp_start_ff;

   // Configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_mode_ff <= 1'b1;
         low_temp_ff <= 19'sd40000;
         high_temp_ff <= 19'sd70000;
         stop_hyst_ff <= '0;
         floor_duty_ff <= '0;
         keep_duty_ff <= 8'd100;
         ceil_duty_ff <= 8'd255;
         curve_gain_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_CURVE_MODE: curve_mode_ff <= csr_ch.wdata[0];
            CSR_LOW_TEMP:   low_temp_ff <= signed'(csr_ch.wdata[TEMP_W-1:0]);
            CSR_HIGH_TEMP:  high_temp_ff <= signed'(csr_ch.wdata[TEMP_W-1:0]);
            CSR_STOP_HYST:  stop_hyst_ff <= csr_ch.wdata[HYST_W-1:0];
            CSR_FLOOR_DUTY: floor_duty_ff <= csr_ch.wdata[DUTY_W-1:0];
            CSR_KEEP_DUTY:  keep_duty_ff <= csr_ch.wdata[DUTY_W-1:0];
            CSR_CEIL_DUTY:  ceil_duty_ff <= csr_ch.wdata[DUTY_W-1:0];
            CSR_CURVE_GAIN: curve_gain_ff <= csr_ch.wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Temperature after hysteresis and window classification
   assign temp_ext = TADJ_W'(req_temperature);
   assign hyst_ext = signed'({{(TADJ_W-HYST_W){1'b0}}, stop_hyst_ff});
   assign t_in = (req_tach_speed == '0) ? (temp_ext - hyst_ext) : temp_ext;
   assign low_ext = TADJ_W'(low_temp_ff);
   assign high_ext = TADJ_W'(high_temp_ff);
   assign below = t_ff < low_ext;
   assign above = t_ff > high_ext;
   assign diff = t_ff - low_ext;

   assign status.window_out = below || above;
   assign status.quadratic = curve_mode_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ch.ready;

   // Shared multiplier
   always_comb begin
      mul_a = curve_gain_ff;
      mul_b = x_ff[MUL_W-1:0];
      if (cmd.square) begin
         mul_a = MUL_W'(d_ff);
         mul_b = MUL_W'(d_ff);
      end else if (cmd.mul_hi) begin
         mul_a = curve_gain_ff;
         mul_b = MUL_W'(x_ff[X_W-1:GAIN_W]);
      end
   end

   assign prod = mul_a * mul_b;

   // Curve sum: drop fraction bits, saturate, add the keep duty, saturate
   assign term = {1'b0, hi_ff} + (HI_W+1)'(acc_ff);
   assign term_sat = (term > (HI_W+1)'(DUTY_MAX)) ? DUTY_MAX : term[DUTY_W-1:0];
   assign curve_sum = {1'b0, keep_duty_ff} + {1'b0, term_sat};

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         t_ff <= t_in;
         present_ff <= req_present_duty;
         stopped_ff <= (req_tach_speed == '0);
      end
      if (cmd.setup) begin
         d_ff <= diff[DIFF_W-1:0];
         x_ff <= X_W'(diff[DIFF_W-1:0]);
         target_ff <= below ? floor_duty_ff : ceil_duty_ff;
      end
      if (cmd.square) begin
         x_ff <= prod[X_W-1:0];
      end
      if (cmd.mul_lo) begin
         acc_ff <= prod[PROD_W-1:MUL_W];
      end
      if (cmd.mul_hi) begin
         hi_ff <= prod[HI_W-1:0];
      end
      if (cmd.sum) begin
         target_ff <= curve_sum[DUTY_W] ? DUTY_MAX : curve_sum[DUTY_W-1:0];
      end
   end

   // Ramp limiting and stopped-fan hold
   assign step_inc = (step_ff == STEP_MAX) ? STEP_MAX : step_ff + 1'b1;
   assign ramp_sum = (DUTY_W+2)'(present_ff) + (DUTY_W+2)'(step_inc);

   always_comb begin
      nd = target_ff;
      step_in = '0;
      step_dbl = '0;
      if ((target_ff > present_ff) && (ramp_sum < (DUTY_W+2)'(target_ff))) begin
         nd = ramp_sum[DUTY_W-1:0];
         step_in = step_inc;
      end
      if (stopped_ff && (nd < keep_duty_ff)) begin
         nd = '0;
         step_dbl = {step_in, 1'b0};
         step_in = (step_dbl > (STEP_W+1)'(STEP_MAX)) ? STEP_MAX : step_dbl[STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            step_ff <= step_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_duty_ff <= nd;
         rsp_start_ff <= stopped_ff && (nd != '0);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.new_duty = rsp_duty_ff;
   assign rsp_ch.start_pulse = rsp_start_ff;

endmodule
